// ===== hdl/dtv_pkg.sv =====
// dtv_pkg: constants, types and helpers of the detection track validator
// no dependencies
package dtv_pkg;
  localparam int unsigned HistDepth = 16;
  localparam int unsigned HistIdxW = $clog2(HistDepth);
  localparam int unsigned FillW = $clog2(HistDepth + 1);
  localparam int unsigned CoordBits = 16;
  localparam int unsigned PredW = CoordBits + 2;
  localparam int unsigned ConfW = 11;
  localparam int unsigned SumW = ConfW + FillW;
  localparam int unsigned PixW = 13;
  localparam int unsigned NumLanes = 4;

  localparam logic [2:0] RegMinConf = 3'd0;
  localparam logic [2:0] RegMinDet = 3'd1;
  localparam logic [2:0] RegHistLen = 3'd2;
  localparam logic [2:0] RegRoiExp = 3'd3;
  localparam logic [2:0] RegImgW = 3'd4;
  localparam logic [2:0] RegImgH = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROI,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic signed [PredW-1:0] px;
    logic signed [PredW-1:0] py;
  } lane_res_t;
endpackage

// ===== hdl/dtv_lane.sv =====
// dtv_lane: linear prediction of one corner
// depends on dtv_pkg
module dtv_lane (
  input  logic [dtv_pkg::CoordBits-1:0] cur_x_i,
  input  logic [dtv_pkg::CoordBits-1:0] cur_y_i,
  input  logic [dtv_pkg::CoordBits-1:0] prev_x_i,
  input  logic [dtv_pkg::CoordBits-1:0] prev_y_i,
  input  logic                          ready_i,
  output dtv_pkg::lane_res_t            res_o
);
  import dtv_pkg::*;
  logic signed [PredW+1:0] tx, ty;
  always_comb begin
    tx = (PredW+2)'(3 * $signed({2'b00, cur_x_i}) - $signed({4'b0000, prev_x_i}));
    ty = (PredW+2)'(3 * $signed({2'b00, cur_y_i}) - $signed({4'b0000, prev_y_i}));
    if (ready_i) begin
      res_o.px = PredW'(tx >>> 1);
      res_o.py = PredW'(ty >>> 1);
    end else begin
      res_o.px = PredW'({2'b00, cur_x_i});
      res_o.py = PredW'({2'b00, cur_y_i});
    end
  end
endmodule

// ===== hdl/dtv_merge.sv =====
// dtv_merge: bounding box over the four lanes' corners and region of interest
// depends on dtv_pkg
module dtv_merge (
  input  logic [4*dtv_pkg::CoordBits-1:0] xs_i,
  input  logic [4*dtv_pkg::CoordBits-1:0] ys_i,
  input  logic [10:0]                     roi_exp_i,
  input  logic [dtv_pkg::PixW-1:0]        img_w_i,
  input  logic [dtv_pkg::PixW-1:0]        img_h_i,
  output logic [dtv_pkg::PixW-1:0]        rx_o,
  output logic [dtv_pkg::PixW-1:0]        ry_o,
  output logic [dtv_pkg::PixW-1:0]        rw_o,
  output logic [dtv_pkg::PixW-1:0]        rh_o
);
  import dtv_pkg::*;
  localparam int unsigned NW = CoordBits + 14;
  logic [CoordBits-1:0] minx, maxx, miny, maxy, sx, sy, vx, vy;
  logic signed [NW:0] nx, ny, rmx, rmy, gx, gy;
  logic signed [11:0] ef;
  logic [PixW:0] ox, oy;
  always_comb begin
    minx = xs_i[CoordBits-1:0]; maxx = minx;
    miny = ys_i[CoordBits-1:0]; maxy = miny;
    for (int i = 1; i < 4; i++) begin
      vx = xs_i[i*CoordBits +: CoordBits];
      vy = ys_i[i*CoordBits +: CoordBits];
      if (vx < minx) minx = vx;
      if (vx > maxx) maxx = vx;
      if (vy < miny) miny = vy;
      if (vy > maxy) maxy = vy;
    end
    sx = maxx - minx;
    sy = maxy - miny;
    // growth beyond one, negative when the box shrinks
    ef = $signed({1'b0, roi_exp_i}) - 12'sd256;
    nx = $signed((NW+1)'({minx, 9'd0})) - $signed({1'b0, sx}) * ef;
    ny = $signed((NW+1)'({miny, 9'd0})) - $signed({1'b0, sy}) * ef;
    ox = (nx <= 0) ? '0 : (PixW+1)'(nx >>> 13);
    oy = (ny <= 0) ? '0 : (PixW+1)'(ny >>> 13);
    gx = $signed((NW+1)'(sx) * (NW+1)'(roi_exp_i)) >>> 12;
    gy = $signed((NW+1)'(sy) * (NW+1)'(roi_exp_i)) >>> 12;
    rmx = $signed((NW+1)'(img_w_i)) - $signed((NW+1)'(ox));
    rmy = $signed((NW+1)'(img_h_i)) - $signed((NW+1)'(oy));
    if (gx < rmx) rmx = gx;
    if (gy < rmy) rmy = gy;
    rx_o = PixW'(ox);
    ry_o = PixW'(oy);
    rw_o = (rmx > 0) ? PixW'(rmx) : '0;
    rh_o = (rmy > 0) ? PixW'(rmy) : '0;
  end
endmodule

// ===== hdl/dtv_window.sv =====
// dtv_window: confidence window, hit run, lock and serial mean divider
// depends on dtv_pkg
module dtv_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic                        div_start_i,
  input  logic [dtv_pkg::ConfW-1:0]   conf_i,
  input  logic [10:0]                 min_conf_i,
  input  logic [7:0]                  min_det_i,
  input  logic [4:0]                  hist_len_i,
  output logic                        div_done_o,
  output logic [dtv_pkg::ConfW-1:0]   mean_o,
  output logic                        valid_o,
  output logic                        locked_o
);
  import dtv_pkg::*;
  logic [ConfW-1:0] win_q [HistDepth];
  logic [SumW-1:0] sum_q, sum_d;
  logic [FillW-1:0] fill_q, fill_d, len;
  logic [HistIdxW-1:0] head_q, old_idx;
  logic [7:0] hits_q, hits_d;
  logic lock_q, lock_d;
  logic [SumW-1:0] rem_q, quo_q;
  logic [4:0] cnt_q;
  logic busy_q;
  logic [SumW:0] trial;

  always_comb begin
    if (hist_len_i < 5'd2) len = FillW'(2);
    else if (32'(hist_len_i) > HistDepth) len = FillW'(HistDepth);
    else len = FillW'(hist_len_i);
    old_idx = head_q - HistIdxW'(fill_q);
    fill_d = fill_q;
    sum_d = sum_q;
    if (fill_q < len) fill_d = fill_q + 1'b1;
    else sum_d = sum_q - SumW'(win_q[old_idx]);
    sum_d = sum_d + SumW'(conf_i);
    hits_d = hits_q;
    if (conf_i > min_conf_i) begin
      if (hits_q != 8'hff) hits_d = hits_q + 1'b1;
    end else begin
      hits_d = '0;
    end
    lock_d = lock_q | (hits_d >= min_det_i);
    trial = {rem_q, quo_q[SumW-1]} - (SumW+1)'(fill_q);
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) win_q[head_q] <= conf_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0; fill_q <= '0; head_q <= '0; hits_q <= '0; lock_q <= 1'b0;
      busy_q <= 1'b0; cnt_q <= '0; rem_q <= '0; quo_q <= '0;
    end else begin
      if (upd_i) begin
        sum_q <= sum_d; fill_q <= fill_d; head_q <= head_q + 1'b1;
        hits_q <= hits_d; lock_q <= lock_d;
      end
      if (div_start_i) begin
        busy_q <= 1'b1; cnt_q <= 5'(SumW); rem_q <= '0; quo_q <= sum_q;
      end else if (busy_q) begin
        if (!trial[SumW]) rem_q <= trial[SumW-1:0];
        else rem_q <= {rem_q[SumW-2:0], quo_q[SumW-1]};
        quo_q <= {quo_q[SumW-2:0], ~trial[SumW]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) busy_q <= 1'b0;
      end
    end
  end

  assign div_done_o = busy_q && (cnt_q == 5'd1);
  assign mean_o = ConfW'(quo_q);
  assign valid_o = lock_q && (32'(sum_q) > 32'(min_conf_i) * 32'(fill_q));
  assign locked_o = lock_q;
endmodule

// ===== hdl/detection_track_validator_top.sv =====
// channel  | handshake       | payload
// input    | in_valid/ready  | corner0..3 x/y, confidence
// output   | out_valid/ready | corner_index, prediction, status, region, last
// config   | apb             | six registers at 4*i
// an item goes through the divider start register, the 16-step serial mean divider,
// the region state and four results; the next item is taken only in idle, once the last
// result of the previous item has been taken, so the divider sets the pace
// reset clears registers to defaults and all track state; output stalls hold the result
module detection_track_validator_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [dtv_pkg::CoordBits-1:0] corner0_x_i, corner0_y_i, corner1_x_i,
  input  logic [dtv_pkg::CoordBits-1:0] corner1_y_i, corner2_x_i, corner2_y_i,
  input  logic [dtv_pkg::CoordBits-1:0] corner3_x_i, corner3_y_i,
  input  logic [10:0] confidence_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [1:0] corner_index_o,
  output logic signed [dtv_pkg::PredW-1:0] predicted_x_o,
  output logic signed [dtv_pkg::PredW-1:0] predicted_y_o,
  output logic prediction_ready_o,
  output logic track_valid_o,
  output logic track_locked_o,
  output logic [10:0] mean_confidence_o,
  output logic [12:0] roi_x_o,
  output logic [12:0] roi_y_o,
  output logic [12:0] roi_width_o,
  output logic [12:0] roi_height_o,
  output logic last_o
);
  import dtv_pkg::*;
  state_e st_q, st_d;
  logic [10:0] min_conf_q, roi_exp_q;
  logic [7:0] min_det_q;
  logic [4:0] hist_q;
  logic [12:0] img_w_q, img_h_q;
  logic [4*CoordBits-1:0] cx_q, cy_q, px_q, py_q;
  logic seen_q, ready_q, div_go_q;
  logic [1:0] idx_q;
  logic accept, div_done, wvalid, wlocked;
  logic [10:0] mean;
  logic [12:0] rx, ry, rw, rh, rx_q, ry_q, rw_q, rh_q;
  lane_res_t res [NumLanes];
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  always_comb begin
    case (ridx)
      RegMinConf: prdata = 32'(min_conf_q);
      RegMinDet:  prdata = 32'(min_det_q);
      RegHistLen: prdata = 32'(hist_q);
      RegRoiExp:  prdata = 32'(roi_exp_q);
      RegImgW:    prdata = 32'(img_w_q);
      RegImgH:    prdata = 32'(img_h_q);
      default:    prdata = '0;
    endcase
  end

  assign in_ready_o = (st_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (accept) st_d = ST_DIV;
      ST_DIV:  if (div_done) st_d = ST_ROI;
      ST_ROI:  st_d = ST_EMIT;
      ST_EMIT: if (out_ready_i && idx_q == 2'd3) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  dtv_window u_win (
    .clk_i, .rst_ni, .upd_i(accept), .div_start_i(div_go_q),
    .conf_i(confidence_i), .min_conf_i(min_conf_q), .min_det_i(min_det_q),
    .hist_len_i(hist_q), .div_done_o(div_done), .mean_o(mean),
    .valid_o(wvalid), .locked_o(wlocked)
  );

  dtv_merge u_merge (
    .xs_i(cx_q), .ys_i(cy_q), .roi_exp_i(roi_exp_q), .img_w_i(img_w_q),
    .img_h_i(img_h_q), .rx_o(rx), .ry_o(ry), .rw_o(rw), .rh_o(rh)
  );

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    dtv_lane u_lane (
      .cur_x_i(cx_q[g*CoordBits +: CoordBits]), .cur_y_i(cy_q[g*CoordBits +: CoordBits]),
      .prev_x_i(px_q[g*CoordBits +: CoordBits]), .prev_y_i(py_q[g*CoordBits +: CoordBits]),
      .ready_i(ready_q), .res_o(res[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; min_conf_q <= 11'd512; min_det_q <= 8'd3; hist_q <= 5'd8;
      roi_exp_q <= 11'd384; img_w_q <= 13'd640; img_h_q <= 13'd480;
      seen_q <= 1'b0; ready_q <= 1'b0; idx_q <= '0; div_go_q <= 1'b0;
    end else begin
      st_q <= st_d;
      div_go_q <= accept;
      if (psel && penable && pwrite) begin
        case (ridx)
          RegMinConf: min_conf_q <= pwdata[10:0];
          RegMinDet:  min_det_q <= pwdata[7:0];
          RegHistLen: hist_q <= pwdata[4:0];
          RegRoiExp:  roi_exp_q <= pwdata[10:0];
          RegImgW:    img_w_q <= pwdata[12:0];
          RegImgH:    img_h_q <= pwdata[12:0];
          default: ;
        endcase
      end
      if (accept) begin
        ready_q <= seen_q; seen_q <= 1'b1; idx_q <= '0;
      end
      if (st_q == ST_EMIT && out_ready_i) idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= cx_q; py_q <= cy_q;
      cx_q <= {corner3_x_i, corner2_x_i, corner1_x_i, corner0_x_i};
      cy_q <= {corner3_y_i, corner2_y_i, corner1_y_i, corner0_y_i};
    end
    if (st_q == ST_ROI) begin
      rx_q <= rx; ry_q <= ry; rw_q <= rw; rh_q <= rh;
    end
  end

  assign out_valid_o = (st_q == ST_EMIT);
  assign corner_index_o = idx_q;
  assign predicted_x_o = res[idx_q].px;
  assign predicted_y_o = res[idx_q].py;
  assign prediction_ready_o = ready_q;
  assign track_valid_o = wvalid;
  assign track_locked_o = wlocked;
  assign mean_confidence_o = mean;
  assign roi_x_o = rx_q;
  assign roi_y_o = ry_q;
  assign roi_width_o = rw_q;
  assign roi_height_o = rh_q;
  assign last_o = (idx_q == 2'd3);
endmodule

// ===== hdl/dtv_checker.sv =====
// dtv_checker: port-level checks of the detection track validator
// depends on detection_track_validator_top
module dtv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [1:0] corner_index_o,
  input logic last_o
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while emitting");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second item taken");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (corner_index_o == 2'd3))) else $error("last wrong");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o &&
    corner_index_o == $past(corner_index_o) + 2'd1) else $error("index skip");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(corner_index_o))
    else $error("result dropped");
endmodule

bind detection_track_validator_top dtv_checker u_dtv_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .corner_index_o, .last_o
);
